// ----- hw/rtl/olad_pkg.sv -----
`default_nettype none

package olad_pkg;

  localparam int unsigned CAPACITY_DEF = 16;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_DONE     = 2'd0;
  localparam status_t ST_FULL     = 2'd1;
  localparam status_t ST_NOTFOUND = 2'd2;
  localparam status_t ST_EMPTY    = 2'd3;

  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

endpackage

`default_nettype wire

// ----- hw/rtl/olad_if.sv -----
`default_nettype none

interface olad_in_if;
  import olad_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       command;
  logic signed [VALUE_W-1:0]  value;

  modport source (output valid, command, value, input ready);
  modport sink   (input valid, command, value, output ready);
endinterface

interface olad_out_if;
  import olad_pkg::*;

  logic                valid;
  logic                ready;
  status_t             status;
  logic [COUNT_W-1:0]  entry_count;

  modport source (output valid, status, entry_count, input ready);
  modport sink   (input valid, status, entry_count, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/olad_ram.sv -----
`default_nettype none

module olad_ram #(
  parameter  int unsigned WIDTH = 32,
  parameter  int unsigned DEPTH = 16,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ordered_list_append_delete_unit.sv -----
// Ordered list of signed 32-bit values with append at the tail and remove of
// the first matching value, kept as a circular doubly linked list in RAM.
// in_if carries one command per transaction (append or remove plus a value);
// out_if returns one transaction per command: a status and the entry count
// after the command. One command is in flight at a time.
// From acceptance the command steps through states before its result is
// loaded into out_if: append passes S_ALINK and S_ALINK2 (S_ALINK2 is skipped
// for an empty list), full list goes straight to S_DONE; remove stays in
// S_RCMP while k entries are compared (1..count), empty list goes straight
// to S_DONE. The result is loaded in S_DONE, and the next command can be
// taken in the cycle after the result is loaded. The search walk reads one
// node per cycle from the value and link RAMs.
// Freed slots go onto a free stack in RAM; slots never used are handed out
// by a fill counter, so no clearing pass is needed after reset.
// Reset (synchronous, rst_n low) empties the list and drops any pending
// result. A stalled receiver holds the result in the output register; the
// block still takes the next command and parks its result until out_if frees.
`default_nettype none

module ordered_list_append_delete_unit #(
  parameter int unsigned CAPACITY = olad_pkg::CAPACITY_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  olad_in_if.sink      in_if,
  olad_out_if.source   out_if
);
  import olad_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALINK,
    S_ALINK2,
    S_RCMP,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  logic [VALUE_W-1:0] value_r, value_nxt;
  logic [AW-1:0]      head_r, head_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      fill_r, fill_nxt;
  logic [CW-1:0]      fsp_r, fsp_nxt;
  logic [AW-1:0]      cur_r, cur_nxt;
  logic [CW-1:0]      iter_r, iter_nxt;
  logic [AW-1:0]      slot_r, slot_nxt;
  logic [AW-1:0]      tail_r, tail_nxt;
  status_t            res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;

  // node store and free stack
  logic [AW-1:0]      rd_addr;
  logic [VALUE_W-1:0] val_rdata;
  logic [AW-1:0]      nx_rdata, pv_rdata, fs_rdata;
  logic               val_we, nx_we, pv_we, fs_we;
  logic [AW-1:0]      val_waddr, nx_waddr, pv_waddr;
  logic [AW-1:0]      nx_wdata, pv_wdata;
  logic [AW-1:0]      fs_raddr, fs_waddr;
  logic [CW-1:0]      fsp_dec;

  logic          accept;
  logic          list_empty;
  logic          match;
  logic          last_iter;
  logic [AW-1:0] alloc_slot;

  assign accept     = in_if.valid && in_if.ready;
  assign list_empty = (count_r == '0);
  assign match      = (val_rdata == value_r);
  assign last_iter  = ((iter_r + ONE_C) == count_r);
  assign fsp_dec    = fsp_r - ONE_C;
  assign fs_raddr   = fsp_dec[AW-1:0];
  assign fs_waddr   = fsp_r[AW-1:0];
  // reuse a freed slot if any, otherwise the next never-used one
  assign alloc_slot = (fsp_r != '0) ? fs_rdata : fill_r[AW-1:0];
  // the walk follows the forward link just read
  assign rd_addr    = (state_r == S_RCMP) ? nx_rdata : head_r;

  assign in_if.ready        = (state_r == S_IDLE);
  assign out_if.valid       = out_valid_r;
  assign out_if.status      = out_status_r;
  assign out_if.entry_count = out_count_r;

  olad_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (value_r),
    .raddr (rd_addr),
    .rdata (val_rdata)
  );

  olad_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_next_ram (
    .clk   (clk),
    .we    (nx_we),
    .waddr (nx_waddr),
    .wdata (nx_wdata),
    .raddr (rd_addr),
    .rdata (nx_rdata)
  );

  olad_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_prev_ram (
    .clk   (clk),
    .we    (pv_we),
    .waddr (pv_waddr),
    .wdata (pv_wdata),
    .raddr (rd_addr),
    .rdata (pv_rdata)
  );

  olad_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_free_ram (
    .clk   (clk),
    .we    (fs_we),
    .waddr (fs_waddr),
    .wdata (cur_r),
    .raddr (fs_raddr),
    .rdata (fs_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    value_nxt      = value_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    fill_nxt       = fill_r;
    fsp_nxt        = fsp_r;
    cur_nxt        = cur_r;
    iter_nxt       = iter_r;
    slot_nxt       = slot_r;
    tail_nxt       = tail_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    val_we         = 1'b0;
    nx_we          = 1'b0;
    pv_we          = 1'b0;
    fs_we          = 1'b0;
    val_waddr      = alloc_slot;
    nx_waddr       = alloc_slot;
    pv_waddr       = alloc_slot;
    nx_wdata       = alloc_slot;
    pv_wdata       = alloc_slot;

    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          value_nxt = in_if.value;
          case (in_if.command)
            CMD_APPEND: begin
              if (count_r == CAP_C) begin
                res_nxt   = ST_FULL;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_ALINK;
              end
            end
            CMD_REMOVE: begin
              if (list_empty) begin
                res_nxt   = ST_EMPTY;
                state_nxt = S_DONE;
              end else begin
                cur_nxt   = head_r;
                iter_nxt  = '0;
                state_nxt = S_RCMP;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_ALINK: begin
        // new node: value and its own links; prev of head is the tail
        val_we   = 1'b1;
        nx_we    = 1'b1;
        pv_we    = 1'b1;
        nx_wdata = list_empty ? alloc_slot : head_r;
        pv_wdata = list_empty ? alloc_slot : pv_rdata;
        slot_nxt = alloc_slot;
        tail_nxt = pv_rdata;
        if (fsp_r != '0) begin
          fsp_nxt = fsp_dec;
        end else begin
          fill_nxt = fill_r + ONE_C;
        end
        // count moves with the slot hand-out so the two stay in step
        count_nxt = count_r + ONE_C;
        if (list_empty) begin
          head_nxt  = alloc_slot;
          res_nxt   = ST_DONE;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_ALINK2;
        end
      end

      S_ALINK2: begin
        nx_we     = 1'b1;
        nx_waddr  = tail_r;
        nx_wdata  = slot_r;
        pv_we     = 1'b1;
        pv_waddr  = head_r;
        pv_wdata  = slot_r;
        res_nxt   = ST_DONE;
        state_nxt = S_DONE;
      end

      S_RCMP: begin
        if (match) begin
          fs_we   = 1'b1;
          fsp_nxt = fsp_r + ONE_C;
          if (count_r == ONE_C) begin
            count_nxt = '0;
          end else begin
            nx_we    = 1'b1;
            nx_waddr = pv_rdata;
            nx_wdata = nx_rdata;
            pv_we    = 1'b1;
            pv_waddr = nx_rdata;
            pv_wdata = pv_rdata;
            if (cur_r == head_r) begin
              head_nxt = nx_rdata;
            end
            count_nxt = count_r - ONE_C;
          end
          res_nxt   = ST_DONE;
          state_nxt = S_DONE;
        end else if (last_iter) begin
          res_nxt   = ST_NOTFOUND;
          state_nxt = S_DONE;
        end else begin
          cur_nxt  = nx_rdata;
          iter_nxt = iter_r + ONE_C;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_r;
          out_count_nxt  = COUNT_W'(count_r);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      head_r      <= '0;
      count_r     <= '0;
      fill_r      <= '0;
      fsp_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      fill_r      <= fill_nxt;
      fsp_r       <= fsp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r      <= value_nxt;
    cur_r        <= cur_nxt;
    iter_r       <= iter_nxt;
    slot_r       <= slot_nxt;
    tail_r       <= tail_nxt;
    res_r        <= res_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  // slots handed out minus slots on the free stack is the entry count
  a_slot_balance: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r - fsp_r) == count_r)
    else $error("slot accounting out of step with entry count");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_C)
    else $error("entry count above capacity");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RCMP) |-> (iter_r < count_r))
    else $error("search walked past the last entry");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && (out_if.status == ST_EMPTY)) |-> (out_if.entry_count == '0))
    else $error("empty status with non-zero entry count");

endmodule

`default_nettype wire
